/* rtl/gmsrf_pkg.sv */
`timescale 1ns / 1ps

package gmsrf_pkg;

  // Largest group threshold the held store is built for.
  localparam int MAX_GROUP_SIZE = 32;

  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 64;
  localparam int CFG_W     = 6;

  // Run counter holds 0 .. MAX_GROUP_SIZE.
  localparam int CNT_W = $clog2(MAX_GROUP_SIZE + 1);

  // Held store keeps up to MAX_GROUP_SIZE-1 payloads.
  localparam int HELD_DEPTH = MAX_GROUP_SIZE - 1;
  localparam int ADDR_W     = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

  // Command queue between front and back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  typedef enum logic {
    CMD_PASS    = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_kind_e;

  // PASS emits payload once with the last flag set. RELEASE emits cnt held
  // entries starting at entry 0, then payload with the last flag set.
  typedef struct packed {
    cmd_kind_e              kind;
    logic [KEY_W-1:0]       key;
    logic [PAYLOAD_W-1:0]   payload;
    logic [CNT_W-1:0]       cnt;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HELD = 2'd1,
    BK_LAST = 2'd2
  } back_state_e;

  // Zero acts as one; values above MAX_GROUP_SIZE saturate to it.
  function automatic logic [CNT_W-1:0] eff_threshold(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] res;
    if (cfg == '0) begin
      res = CNT_W'(1);
    end else if (int'(cfg) > MAX_GROUP_SIZE) begin
      res = CNT_W'(MAX_GROUP_SIZE);
    end else begin
      res = CNT_W'(cfg);
    end
    return res;
  endfunction

endpackage

/* rtl/gmsrf_ram.sv */
`timescale 1ns / 1ps

module gmsrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 31
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/gmsrf_front.sv */
`timescale 1ns / 1ps

module gmsrf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gmsrf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [gmsrf_pkg::KEY_W-1:0]     s_key_i,
  input  logic [gmsrf_pkg::PAYLOAD_W-1:0] s_payload_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output gmsrf_pkg::cmd_t                 q_cmd_o,
  output logic                            ram_we_o,
  output logic [gmsrf_pkg::ADDR_W-1:0]    ram_waddr_o,
  output logic [gmsrf_pkg::PAYLOAD_W-1:0] ram_wdata_o,
  input  logic                            rel_done_i,
  output logic                            rel_pend_o
);

  import gmsrf_pkg::*;

  logic [CFG_W-1:0] cfg_q;
  logic [KEY_W-1:0] cur_key_q, cur_key_d;
  logic             key_valid_q, key_valid_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic             rel_pend_q, rel_pend_d;

  logic             accept;
  logic             new_grp;
  logic [CNT_W-1:0] thr;
  logic [CNT_W-1:0] run_inc;

  // Input is held off while a release is still being drained, so the held
  // store is never overwritten before the back end has read it.
  assign s_ready_o   = !q_full_i && !rel_pend_q;
  assign accept      = s_valid_i && s_ready_o;
  assign rel_pend_o  = rel_pend_q;
  assign ram_wdata_o = s_payload_i;

  always_comb begin
    thr         = eff_threshold(cfg_q);
    new_grp     = !key_valid_q || (s_key_i != cur_key_q);
    run_inc     = run_q + CNT_W'(1);
    cur_key_d   = cur_key_q;
    key_valid_d = key_valid_q;
    run_d       = run_q;
    q_push_o    = 1'b0;
    q_cmd_o     = '{kind: CMD_PASS, key: s_key_i, payload: s_payload_i, cnt: run_q};
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    if (accept) begin
      if (new_grp) begin
        cur_key_d   = s_key_i;
        key_valid_d = 1'b1;
        run_d       = CNT_W'(1);
        if (thr == CNT_W'(1)) begin
          q_push_o = 1'b1;
        end else begin
          ram_we_o = 1'b1;
        end
      end else if (run_q >= thr) begin
        run_d    = thr;
        q_push_o = 1'b1;
      end else begin
        run_d = run_inc;
        if (run_inc < thr) begin
          // The new record is member number run_q+1 and lands at entry run_q.
          ram_we_o    = 1'b1;
          ram_waddr_o = run_q[ADDR_W-1:0];
        end else begin
          q_push_o     = 1'b1;
          q_cmd_o.kind = CMD_RELEASE;
        end
      end
    end
    rel_pend_d = rel_pend_q;
    if (q_push_o && (q_cmd_o.kind == CMD_RELEASE)) begin
      rel_pend_d = 1'b1;
    end else if (rel_done_i) begin
      rel_pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      cur_key_q   <= '0;
      key_valid_q <= 1'b0;
      run_q       <= '0;
      rel_pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      cur_key_q   <= cur_key_d;
      key_valid_q <= key_valid_d;
      run_q       <= run_d;
      rel_pend_q  <= rel_pend_d;
    end
  end

`ifndef ASSERT_OFF
  a_pend_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rel_pend_q && !rel_done_i) |=> rel_pend_q)
    else $error("release pending flag dropped without a done pulse");
  a_done_only_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_done_i |-> rel_pend_q)
    else $error("release done seen with no release pending");
  a_no_hold_when_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !rel_pend_q)
    else $error("held store written while a release is draining");
`endif

endmodule

/* rtl/gmsrf_queue.sv */
`timescale 1ns / 1ps

module gmsrf_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gmsrf_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output gmsrf_pkg::cmd_t cmd_o
);

  import gmsrf_pkg::*;

  cmd_t            slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (Q_AW + 1)'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (Q_AW + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("command queue read while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (Q_AW + 1)'(Q_DEPTH))
    else $error("command queue count beyond its depth");
`endif

endmodule

/* rtl/gmsrf_back.sv */
`timescale 1ns / 1ps

module gmsrf_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  gmsrf_pkg::cmd_t                 q_cmd_i,
  output logic                            q_pop_o,
  output logic                            ram_re_o,
  output logic [gmsrf_pkg::ADDR_W-1:0]    ram_raddr_o,
  input  logic [gmsrf_pkg::PAYLOAD_W-1:0] ram_rdata_i,
  output logic                            rel_done_o,
  output logic                            m_valid_o,
  input  logic                            m_ready_i,
  output logic [gmsrf_pkg::KEY_W-1:0]     m_key_o,
  output logic [gmsrf_pkg::PAYLOAD_W-1:0] m_payload_o,
  output logic                            m_last_o
);

  import gmsrf_pkg::*;

  back_state_e          state_q, state_d;
  logic [ADDR_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q;
  logic [KEY_W-1:0]     key_q;
  logic [PAYLOAD_W-1:0] pay_q;

  logic                 out_valid_q;
  logic [KEY_W-1:0]     out_key_q;
  logic [PAYLOAD_W-1:0] out_pay_q;
  logic                 out_last_q;

  logic                 slot_free;
  logic [CNT_W-1:0]     idx_nx;
  logic                 more_held;
  logic                 take_rel;
  logic                 load;
  logic [KEY_W-1:0]     load_key;
  logic [PAYLOAD_W-1:0] load_pay;
  logic                 load_last;

  assign slot_free = !out_valid_q || m_ready_i;
  assign idx_nx    = CNT_W'(idx_q) + CNT_W'(1);
  assign more_held = (idx_nx < cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i && (q_cmd_i.kind == CMD_RELEASE)) begin
          state_d = BK_HELD;
        end
      end
      BK_HELD: begin
        if (slot_free && !more_held) begin
          state_d = BK_LAST;
        end
      end
      BK_LAST: begin
        if (slot_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath controls. The read of the next held entry is issued
  // in the cycle its predecessor moves into the output register.
  always_comb begin
    q_pop_o     = 1'b0;
    take_rel    = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    rel_done_o  = 1'b0;
    idx_d       = idx_q;
    load        = 1'b0;
    load_key    = key_q;
    load_pay    = pay_q;
    load_last   = 1'b1;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_cmd_i.kind == CMD_RELEASE) begin
            q_pop_o  = 1'b1;
            take_rel = 1'b1;
            ram_re_o = 1'b1;
            idx_d    = '0;
          end else if (slot_free) begin
            q_pop_o  = 1'b1;
            load     = 1'b1;
            load_key = q_cmd_i.key;
            load_pay = q_cmd_i.payload;
          end
        end
      end
      BK_HELD: begin
        if (slot_free) begin
          load      = 1'b1;
          load_pay  = ram_rdata_i;
          load_last = 1'b0;
          if (more_held) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = idx_nx[ADDR_W-1:0];
            idx_d       = idx_nx[ADDR_W-1:0];
          end
        end
      end
      BK_LAST: begin
        if (slot_free) begin
          load       = 1'b1;
          rel_done_o = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take_rel) begin
      key_q <= q_cmd_i.key;
      pay_q <= q_cmd_i.payload;
      cnt_q <= q_cmd_i.cnt;
    end
    if (load) begin
      out_key_q  <= load_key;
      out_pay_q  <= load_pay;
      out_last_q <= load_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_valid_o   = out_valid_q;
  assign m_key_o     = out_key_q;
  assign m_payload_o = out_pay_q;
  assign m_last_o    = out_last_q;

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_HELD) |-> (idx_nx <= cnt_q))
    else $error("held entry index beyond the release count");
  a_release_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_rel |-> (q_cmd_i.cnt != '0))
    else $error("release command with no held entries");
  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_done_o |=> (state_q == BK_IDLE) && m_valid_o && m_last_o)
    else $error("release did not end with its last beat");
`endif

endmodule

/* rtl/group_min_size_record_filter.sv */
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                     | Content
// ---------+-----+-------------------------------+-------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | group_key, record_payload
// m_axis   | out | m_axis_tvalid / m_axis_tready | out_key, out_payload, run_last=tlast
// cfg      | in  | cfg_we_i (no wait)            | min_group_size
//
// A record that passes or is held is taken at the input whenever the command
// queue is not full and no release is pending. A record that completes a group
// releases its N held records plus itself as N+1 output beats, one per cycle
// while the output is not stalled; the held records are read one at a time
// through the single read port of the held store into the one output register.
// During that release the input is held off until the last beat is loaded.
// Reset clears all control state; the held store needs no clearing.
// Either side may stall at any time: a two-entry command queue sits between
// the classifying front and the emitting back end.

module group_min_size_record_filter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration: min_group_size.
  input  logic                                cfg_we_i,
  input  logic [gmsrf_pkg::CFG_W-1:0]         cfg_wdata_i,
  // Input records.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] group_key, [95:32] record_payload.
  input  logic [95:0]                         s_axis_tdata,
  // Output records.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] out_key, [95:32] out_payload.
  output logic [95:0]                         m_axis_tdata,
  // run_last: set on the final beat caused by one input record.
  output logic                                m_axis_tlast
);

  import gmsrf_pkg::*;

  // Front to queue.
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_cmd_in, q_cmd_out;

  // Held store ports.
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [PAYLOAD_W-1:0] ram_wdata, ram_rdata;

  // Release bookkeeping between back and front.
  logic rel_done, rel_pend;

  logic [KEY_W-1:0]     out_key;
  logic [PAYLOAD_W-1:0] out_payload;

  gmsrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_key_i     (s_axis_tdata[KEY_W-1:0]),
    .s_payload_i (s_axis_tdata[KEY_W+PAYLOAD_W-1:KEY_W]),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_cmd_in),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .rel_done_i  (rel_done),
    .rel_pend_o  (rel_pend)
  );

  gmsrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  // Held payloads of the current group, entry k for its (k+1)-th record.
  gmsrf_ram #(
    .WIDTH (PAYLOAD_W),
    .DEPTH (HELD_DEPTH)
  ) u_held (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  gmsrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd_out),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rel_done_o  (rel_done),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_key_o     (out_key),
    .m_payload_o (out_payload),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {out_payload, out_key};

`ifndef ASSERT_OFF
  // A beat without the last flag can only come from a release in progress.
  a_held_beat_in_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> rel_pend)
    else $error("non-final beat outside a release");
  a_no_input_during_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_pend |-> !q_push)
    else $error("command queued while a release is draining");
  a_push_then_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push && (q_cmd_in.kind == CMD_RELEASE)) |=> rel_pend)
    else $error("release queued without marking it pending");
`endif

endmodule
